[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// No dependencies; clk and rst_n must be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/kal_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the keyword-aware lexer.
// No dependencies; used by every module of the block.
package kal_pkg;

  // Width of the internal length counter and position counter
  localparam int unsigned LEN_W = 8;
  localparam int unsigned POS_W = 16;

  // Widths of the result fields on the port
  localparam int unsigned TOKEN_LEN_W = 8;
  localparam int unsigned START_POS_W = 16;

  // Character codes the automaton looks for
  localparam logic [7:0] CH_I     = 8'h69;  // i
  localparam logic [7:0] CH_N     = 8'h6E;  // n
  localparam logic [7:0] CH_T     = 8'h74;  // t
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ;
  localparam logic [7:0] CH_EQUAL = 8'h3D;  // =
  localparam logic [7:0] CH_MUL   = 8'h2A;  // *
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Input command codes
  typedef enum logic {
    CMD_CHAR  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // Token kinds on the result channel
  typedef enum logic [3:0] {
    KIND_IDENT    = 4'd0,
    KIND_KW_INT   = 4'd1,
    KIND_INTEGER  = 4'd2,
    KIND_PLUS     = 4'd3,
    KIND_MINUS    = 4'd4,
    KIND_SEMI     = 4'd5,
    KIND_EQUAL    = 4'd6,
    KIND_MUL      = 4'd7,
    KIND_GREATER  = 4'd8,
    KIND_GREATER_EQ = 4'd9
  } kind_t;

  // One input item
  typedef struct packed {
    cmd_t       command;
    logic [7:0] char_code;
  } item_t;

  // One result item
  typedef struct packed {
    kind_t                    token_kind;
    logic [TOKEN_LEN_W-1:0]   token_length;
    logic                     length_saturated;
    logic [START_POS_W-1:0]   start_position;
  } token_t;

endpackage

[hdl/kal_in_reg.sv]
`timescale 1ns / 1ps
// Lexer input register: one transaction per cycle while empty or drained.
// Depends on kal_pkg for the item type.
module kal_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  kal_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output kal_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  kal_pkg::item_t item_r;

  // Take a new transaction when the register is empty or being drained
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until it is consumed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[hdl/kal_scan.sv]
`timescale 1ns / 1ps
// Token automaton of the lexer: state registers, next-state logic and the
// result register. Depends on kal_pkg for types, codes and widths.
module kal_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  kal_pkg::item_t  item,
  output logic            advance,
  output logic            out_tvalid,
  input  logic            out_tready,
  output kal_pkg::token_t result
);

  localparam int unsigned LW = kal_pkg::LEN_W;
  localparam int unsigned PW = kal_pkg::POS_W;
  localparam int unsigned TW = kal_pkg::TOKEN_LEN_W;
  localparam int unsigned SW = kal_pkg::START_POS_W;

  typedef enum logic [3:0] {
    CLS_IDLE  = 4'd0,
    CLS_IDENT = 4'd1,
    CLS_I1    = 4'd2,
    CLS_I2    = 4'd3,
    CLS_I3    = 4'd4,
    CLS_DIGIT = 4'd5,
    CLS_PLUS  = 4'd6,
    CLS_MINUS = 4'd7,
    CLS_SEMI  = 4'd8,
    CLS_EQUAL = 4'd9,
    CLS_MUL   = 4'd10,
    CLS_GT    = 4'd11,
    CLS_GE    = 4'd12
  } cls_t;

  cls_t            cls_r, cls_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [PW-1:0]   start_r, start_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic            out_valid_r, out_valid_nxt;
  kal_pkg::token_t res_r;

  logic            is_letter, is_digit, is_alnum;
  logic            extend;
  logic            emit;
  cls_t            cont_cls;
  cls_t            start_cls;
  kal_pkg::kind_t  open_kind;
  logic [7:0]      c;

  assign c = item.char_code;

  // Classify the character
  always_comb begin
    is_letter = ((c >= kal_pkg::CH_LO_A) && (c <= kal_pkg::CH_LO_Z)) ||
                ((c >= kal_pkg::CH_UP_A) && (c <= kal_pkg::CH_UP_Z));
    is_digit  = (c >= kal_pkg::CH_0) && (c <= kal_pkg::CH_9);
    is_alnum  = is_letter || is_digit;
  end

  // Class a new token opens with
  always_comb begin
    if (c == kal_pkg::CH_I)           start_cls = CLS_I1;
    else if (is_letter)               start_cls = CLS_IDENT;
    else if (is_digit)                start_cls = CLS_DIGIT;
    else if (c == kal_pkg::CH_PLUS)   start_cls = CLS_PLUS;
    else if (c == kal_pkg::CH_MINUS)  start_cls = CLS_MINUS;
    else if (c == kal_pkg::CH_SEMI)   start_cls = CLS_SEMI;
    else if (c == kal_pkg::CH_EQUAL)  start_cls = CLS_EQUAL;
    else if (c == kal_pkg::CH_MUL)    start_cls = CLS_MUL;
    else if (c == kal_pkg::CH_GT)     start_cls = CLS_GT;
    else                              start_cls = CLS_IDLE;
  end

  // Decide whether the character continues the open token
  always_comb begin
    extend   = 1'b0;
    cont_cls = CLS_IDLE;
    unique case (cls_r)
      CLS_IDENT, CLS_I3: begin
        if (is_alnum) begin
          extend = 1'b1; cont_cls = CLS_IDENT;
        end
      end
      CLS_I1: begin
        if (c == kal_pkg::CH_N) begin
          extend = 1'b1; cont_cls = CLS_I2;
        end else if (is_alnum) begin
          extend = 1'b1; cont_cls = CLS_IDENT;
        end
      end
      CLS_I2: begin
        if (c == kal_pkg::CH_T) begin
          extend = 1'b1; cont_cls = CLS_I3;
        end else if (is_alnum) begin
          extend = 1'b1; cont_cls = CLS_IDENT;
        end
      end
      CLS_DIGIT: begin
        if (is_digit) begin
          extend = 1'b1; cont_cls = CLS_DIGIT;
        end
      end
      CLS_GT: begin
        if (c == kal_pkg::CH_EQUAL) begin
          extend = 1'b1; cont_cls = CLS_GE;
        end
      end
      default: begin
        extend = 1'b0;
      end
    endcase
  end

  // Kind reported when the open token closes
  always_comb begin
    unique case (cls_r)
      CLS_I3:    open_kind = kal_pkg::KIND_KW_INT;
      CLS_DIGIT: open_kind = kal_pkg::KIND_INTEGER;
      CLS_PLUS:  open_kind = kal_pkg::KIND_PLUS;
      CLS_MINUS: open_kind = kal_pkg::KIND_MINUS;
      CLS_SEMI:  open_kind = kal_pkg::KIND_SEMI;
      CLS_EQUAL: open_kind = kal_pkg::KIND_EQUAL;
      CLS_MUL:   open_kind = kal_pkg::KIND_MUL;
      CLS_GT:    open_kind = kal_pkg::KIND_GREATER;
      CLS_GE:    open_kind = kal_pkg::KIND_GREATER_EQ;
      default:   open_kind = kal_pkg::KIND_IDENT;
    endcase
  end

  // Consume the item when the result register has room
  assign advance = item_valid && (!out_valid_r || out_tready);

  // Next automaton state
  always_comb begin
    cls_nxt   = cls_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    if (advance) begin
      if (item.command == kal_pkg::CMD_FLUSH) begin
        // Flush the open token and clear everything
        emit      = (cls_r != CLS_IDLE);
        cls_nxt   = CLS_IDLE;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        start_nxt = '0;
        pos_nxt   = '0;
      end else begin
        pos_nxt = PW'(pos_r + 1'b1);
        if (extend) begin
          cls_nxt = cont_cls;
          if (&len_r) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = LW'(len_r + 1'b1);
          end
        end else begin
          emit    = (cls_r != CLS_IDLE);
          cls_nxt = start_cls;
          ovf_nxt = 1'b0;
          if (start_cls != CLS_IDLE) begin
            len_nxt   = LW'(1);
            start_nxt = pos_r;
          end else begin
            len_nxt   = '0;
            start_nxt = '0;
          end
        end
      end
    end
  end

  // Result register valid: load on emit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r       <= CLS_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      start_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cls_r       <= cls_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the closed token
  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.token_kind       <= open_kind;
      res_r.token_length     <= TW'(len_r);
      res_r.length_saturated <= ovf_r;
      res_r.start_position   <= SW'(start_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign result     = res_r;

endmodule

[hdl/keyword_aware_lexer.sv]
`timescale 1ns / 1ps
// Keyword-aware lexer: stream channel in, one token transaction out per
// closed token. Instantiates kal_in_reg and kal_scan; uses kal_pkg.
//
// Usage:
//   The input channel carries one character per transaction (in_tuser = 0,
//   in_tdata = ASCII code) or an end-of-text flush (in_tuser = 1). A token
//   closes when a character cannot continue it, or on flush; the output
//   channel then carries its kind, length, saturation flag and start offset.
//   Throughput is one input transaction per clock while the output is not
//   stalled, set by the single pass through the automaton between the input
//   register and the result register. The transaction that closes a token
//   is held in the input register, and the token is then captured in the
//   result register. Spaces and unknown characters produce no output.
//   While the receiver holds out_tready low with a token pending, the
//   input register fills and in_tready drops; nothing is lost.
//   Reset (rst_n low, synchronous) empties both registers, closes any open
//   token and sets the character position to zero.
module keyword_aware_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] token_length, [23:8] start_position
  output logic [4:0]  out_tuser   // [3:0] token_kind, [4] length_saturated
);

  kal_pkg::item_t  in_item;
  kal_pkg::item_t  item;
  kal_pkg::token_t result;
  logic            item_valid;
  logic            advance;

  // Unpack the input transaction
  assign in_item.command   = kal_pkg::cmd_t'(in_tuser);
  assign in_item.char_code = in_tdata;

  kal_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  kal_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .result     (result)
  );

  // Pack the result transaction
  assign out_tdata = {result.start_position, result.token_length};
  assign out_tuser = {result.length_saturated, result.token_kind};

endmodule

[hdl/kal_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the keyword-aware lexer, bound to the top level.
// Depends on assert_macros.svh and kal_pkg.
`include "assert_macros.svh"

module kal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [4:0]  out_tuser
);

  logic [3:0] kind;
  logic [7:0] tok_len;
  logic       op_kind;

  assign kind    = out_tuser[3:0];
  assign tok_len = out_tdata[7:0];
  assign op_kind = (kind == kal_pkg::KIND_PLUS)  || (kind == kal_pkg::KIND_MINUS) ||
                   (kind == kal_pkg::KIND_SEMI)  || (kind == kal_pkg::KIND_EQUAL) ||
                   (kind == kal_pkg::KIND_MUL)   || (kind == kal_pkg::KIND_GREATER);

  // No token may be pending right after reset
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "token valid after reset")

  // Kind code stays in the defined range
  `ASSERT_CLK(a_kind_range, out_tvalid |-> (kind <= kal_pkg::KIND_GREATER_EQ), "bad token kind")

  // Single-character operators are one long, >= is two long
  `ASSERT_CLK(a_op_len, (out_tvalid && op_kind) |-> (tok_len == 8'd1), "operator length")
  `ASSERT_CLK(a_ge_len, (out_tvalid && (kind == kal_pkg::KIND_GREATER_EQ)) |-> (tok_len == 8'd2), "ge length")

  // A stalled transaction holds its payload
  `ASSERT_CLK(a_stall_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled token changed")

endmodule

bind keyword_aware_lexer kal_checker u_kal_checker (.*);
